// ===== src/bpb_pkg.sv =====
// ----------------------------------------------------------------------------
// bpb_pkg
// Types, constants and helper functions shared by the binary to packed BCD
// converter blocks.
// ----------------------------------------------------------------------------
package bpb_pkg;

    localparam int VALUE_W  = 32;
    localparam int DIGITS   = 10;
    localparam int BCD_W    = 4 * DIGITS;
    localparam int COUNT_W  = 4;
    localparam int BITS_PER_STEP = 4;
    localparam int CONV_STEPS    = VALUE_W / BITS_PER_STEP;
    localparam int STEP_W        = $clog2(CONV_STEPS);
    localparam int BCD_BYTES     = DIGITS / 2;
    localparam logic [7:0] PAD_BYTE = 8'h00;

    // One job handed from the converter to the output sequencer.
    typedef struct packed {
        logic [BCD_W-1:0]   bcd;
        logic [COUNT_W-1:0] req;
        logic               le;
    } t_job;

    // Four double dabble iterations: add three to every digit of five or more,
    // then shift in the next binary bit, most significant bit first.
    function automatic logic [BCD_W-1:0] dd4(input logic [BCD_W-1:0] bcd_in,
                                             input logic [BITS_PER_STEP-1:0] bits);
        logic [BCD_W-1:0] r;
        r = bcd_in;
        for (int s = BITS_PER_STEP - 1; s >= 0; s--) begin
            for (int d = 0; d < DIGITS; d++) begin
                if (r[4*d +: 4] >= 4'd5) begin
                    r[4*d +: 4] = r[4*d +: 4] + 4'd3;
                end
            end
            r = {r[BCD_W-2:0], bits[s]};
        end
        return r;
    endfunction

    // Natural byte length: half the significant digit count, rounded up.
    // Zero still gives one byte.
    function automatic logic [COUNT_W-1:0] nat_bytes(input logic [BCD_W-1:0] bcd);
        logic [COUNT_W-1:0] top;
        top = '0;
        for (int d = 1; d < DIGITS; d++) begin
            if (bcd[4*d +: 4] != 4'd0) begin
                top = COUNT_W'(d);
            end
        end
        return (top + COUNT_W'(2)) >> 1;
    endfunction

endpackage

// ===== src/bpb_front.sv =====
// ----------------------------------------------------------------------------
// bpb_front
// Accepts a conversion request and turns the binary value into ten BCD digits,
// four bits per cycle, then hands the job to the queue.
// ----------------------------------------------------------------------------
module bpb_front (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_push,
    input  logic [31:0]                   i_value,
    input  logic [3:0]                    i_byte_count,
    input  logic                          i_little_endian,
    output logic                          o_full,
    output logic                          o_q_push,
    output bpb_pkg::t_job                 o_job,
    input  logic                          i_q_full
);
    import bpb_pkg::*;

    logic                           r_busy;
    logic                           r_done;
    logic [STEP_W-1:0]              r_step;
    logic [VALUE_W-BITS_PER_STEP-1:0] r_val;
    logic [BCD_W-1:0]               r_bcd;
    logic [COUNT_W-1:0]             r_req;
    logic                           r_le;
    logic                           accept;

    assign o_q_push = r_busy && r_done && !i_q_full;
    assign o_full   = r_busy && !o_q_push;
    assign accept   = i_push && !o_full;
    assign o_job    = '{bcd: r_bcd, req: r_req, le: r_le};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_step <= '0;
        end else if (accept) begin
            // The first four bits are converted on the way in.
            r_busy <= 1'b1;
            r_done <= 1'b0;
            r_step <= STEP_W'(1);
            r_bcd  <= dd4('0, i_value[VALUE_W-1 -: BITS_PER_STEP]);
            r_val  <= i_value[VALUE_W-BITS_PER_STEP-1:0];
            r_req  <= i_byte_count;
            r_le   <= i_little_endian;
        end else if (o_q_push) begin
            r_busy <= 1'b0;
        end else if (r_busy && !r_done) begin
            r_bcd  <= dd4(r_bcd, r_val[VALUE_W-BITS_PER_STEP-1 -: BITS_PER_STEP]);
            r_val  <= {r_val[VALUE_W-2*BITS_PER_STEP-1:0], {BITS_PER_STEP{1'b0}}};
            r_step <= r_step + STEP_W'(1);
            if (r_step == STEP_W'(CONV_STEPS - 1)) begin
                r_done <= 1'b1;
            end
        end
    end

endmodule

// ===== src/bpb_queue.sv =====
// ----------------------------------------------------------------------------
// bpb_queue
// Two-entry job queue between the converter and the output sequencer.
// ----------------------------------------------------------------------------
module bpb_queue (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_wr,
    input  bpb_pkg::t_job i_job,
    output logic          o_full,
    input  logic          i_rd,
    output bpb_pkg::t_job o_job,
    output logic          o_empty
);
    import bpb_pkg::*;

    localparam int DEPTH = 2;

    t_job       r_mem [DEPTH];
    logic       r_wr_ptr;
    logic       r_rd_ptr;
    logic [1:0] r_count;
    logic       do_wr;
    logic       do_rd;

    assign o_full  = (r_count == 2'(DEPTH));
    assign o_empty = (r_count == 2'd0);
    assign do_wr   = i_wr && !o_full;
    assign do_rd   = i_rd && !o_empty;
    assign o_job   = r_mem[r_rd_ptr];

    always_ff @(posedge i_clk) begin
        if (do_wr) begin
            r_mem[r_wr_ptr] <= i_job;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= 1'b0;
            r_rd_ptr <= 1'b0;
            r_count  <= 2'd0;
        end else begin
            if (do_wr) begin
                r_wr_ptr <= ~r_wr_ptr;
            end
            if (do_rd) begin
                r_rd_ptr <= ~r_rd_ptr;
            end
            if (do_wr && !do_rd) begin
                r_count <= r_count + 2'd1;
            end else if (do_rd && !do_wr) begin
                r_count <= r_count - 2'd1;
            end
        end
    end

endmodule

// ===== src/bpb_back.sv =====
// ----------------------------------------------------------------------------
// bpb_back
// Output sequencer: works out the byte count of a job and emits its packed
// BCD bytes one per transaction in the requested order.
// ----------------------------------------------------------------------------
module bpb_back #(
    parameter int MAX_BYTES = 8
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  bpb_pkg::t_job i_job,
    input  logic          i_q_empty,
    output logic          o_q_rd,
    output logic [7:0]    o_bcd_byte,
    output logic          o_last,
    output logic          o_empty,
    input  logic          i_pop
);
    import bpb_pkg::*;

    logic               r_active;
    logic [COUNT_W-1:0] r_idx;
    logic [COUNT_W-1:0] r_cnt;
    logic [BCD_W-1:0]   r_bcd;
    logic               r_le;
    logic [COUNT_W-1:0] k;
    logic [COUNT_W-1:0] want;
    logic [COUNT_W-1:0] n_cnt;
    logic               done;

    assign o_empty = !r_active;
    assign o_last  = (r_idx + COUNT_W'(1) == r_cnt);
    assign done    = r_active && i_pop && o_last;
    assign o_q_rd  = (!r_active || done) && !i_q_empty;

    // Byte position counted from the least significant end.
    assign k = r_le ? r_idx : (r_cnt - COUNT_W'(1) - r_idx);

    always_comb begin
        case (k)
            4'd0:    o_bcd_byte = r_bcd[7:0];
            4'd1:    o_bcd_byte = r_bcd[15:8];
            4'd2:    o_bcd_byte = r_bcd[23:16];
            4'd3:    o_bcd_byte = r_bcd[31:24];
            4'd4:    o_bcd_byte = r_bcd[39:32];
            default: o_bcd_byte = PAD_BYTE;
        endcase
    end

    always_comb begin
        want  = (i_job.req == '0) ? nat_bytes(i_job.bcd) : i_job.req;
        n_cnt = (int'(want) > MAX_BYTES) ? COUNT_W'(MAX_BYTES) : want;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_active <= 1'b0;
            r_idx    <= '0;
            r_cnt    <= '0;
        end else if (o_q_rd) begin
            r_active <= 1'b1;
            r_idx    <= '0;
            r_cnt    <= n_cnt;
            r_bcd    <= i_job.bcd;
            r_le     <= i_job.le;
        end else if (done) begin
            r_active <= 1'b0;
        end else if (r_active && i_pop) begin
            r_idx <= r_idx + COUNT_W'(1);
        end
    end

endmodule

// ===== src/binary_to_packed_bcd_bytes.sv =====
// ----------------------------------------------------------------------------
// binary_to_packed_bcd_bytes
// Converts a 32-bit unsigned value to packed BCD bytes, natural length or a
// requested count, emitted in either byte order with the final byte marked.
// ----------------------------------------------------------------------------
//  Channel | Handshake          | Payload
//  --------+--------------------+-----------------------------------------------
//  input   | push / full        | i_value, i_byte_count, i_little_endian
//  result  | pop / empty        | o_bcd_byte, o_last
//
// The converter turns four value bits per cycle through the double dabble adjust
// and takes the next item as it hands its finished job to the queue. Output gives
// 1 to MAX_BYTES bytes per item, one per pop, and takes a queued job as one ends.
// A two-job queue sits between converter and sequencer so either side may stall.
// Reset is synchronous and active low; it clears all control state.
module binary_to_packed_bcd_bytes #(
    parameter int MAX_BYTES = 8
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        push,
    output logic        full,
    input  logic [31:0] i_value,
    input  logic [3:0]  i_byte_count,
    input  logic        i_little_endian,
    output logic        empty,
    input  logic        pop,
    output logic [7:0]  o_bcd_byte,
    output logic        o_last
);
    import bpb_pkg::*;

    t_job wr_job;
    t_job rd_job;
    logic q_wr;
    logic q_full;
    logic q_rd;
    logic q_empty;

    bpb_front u_front (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_push          (push),
        .i_value         (i_value),
        .i_byte_count    (i_byte_count),
        .i_little_endian (i_little_endian),
        .o_full          (full),
        .o_q_push        (q_wr),
        .o_job           (wr_job),
        .i_q_full        (q_full)
    );

    bpb_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_wr    (q_wr),
        .i_job   (wr_job),
        .o_full  (q_full),
        .i_rd    (q_rd),
        .o_job   (rd_job),
        .o_empty (q_empty)
    );

    bpb_back #(
        .MAX_BYTES (MAX_BYTES)
    ) u_back (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_job      (rd_job),
        .i_q_empty  (q_empty),
        .o_q_rd     (q_rd),
        .o_bcd_byte (o_bcd_byte),
        .o_last     (o_last),
        .o_empty    (empty),
        .i_pop      (pop)
    );

endmodule

// ===== tb/sv/tb_binary_to_packed_bcd_bytes.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_binary_to_packed_bcd_bytes
// Drives 32-bit values with natural, padded, truncated and saturated byte
// counts in both byte orders, and checks every packed BCD byte and its final
// marker against literal table bytes or a decimal-digit predictor. The sender
// works in bursts, the receiver stalls on a rotating pattern, and one long
// receiver hold-off fills the block so that its input stalls.
// ----------------------------------------------------------------------------
module tb_binary_to_packed_bcd_bytes;

    import bpb_pkg::*;

    localparam int MAX_BYTES    = 8;
    localparam int RANDOM_ITEMS = 450;
    localparam int LONG_HOLD    = 300;
    localparam int SETTLE       = 40;
    localparam int STALL_LIMIT  = 3000;
    localparam int TABLE_ROWS   = 21;

    typedef struct packed {
        logic [7:0] bcd;
        logic       last;
    } t_bcd_byte;

    // A literal of n_lit bytes is left-aligned: the first byte out is lit[63:56].
    typedef struct packed {
        logic [31:0] value;
        logic [3:0]  cnt;
        logic        le;
        logic [3:0]  n_lit;
        logic [63:0] lit;
    } t_stim_row;

    typedef enum logic [1:0] {RX_FREE, RX_COIN, RX_SPARSE, RX_MOSTLY} t_rx_pattern;

    logic        i_clk;
    logic        i_rst_n;
    logic        push;
    logic        full;
    logic [31:0] i_value;
    logic [3:0]  i_byte_count;
    logic        i_little_endian;
    logic        empty;
    logic        pop;
    logic [7:0]  o_bcd_byte;
    logic        o_last;

    t_bcd_byte   bcd_bytes_due[$];
    t_bcd_byte   due_byte;
    t_stim_row   stim_table[TABLE_ROWS];
    int          mismatch_count = 0;
    int          quiet_cycles   = 0;
    bit          hold_pending   = 1'b0;

    binary_to_packed_bcd_bytes #(
        .MAX_BYTES(MAX_BYTES)
    ) u_top (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .push           (push),
        .full           (full),
        .i_value        (i_value),
        .i_byte_count   (i_byte_count),
        .i_little_endian(i_little_endian),
        .empty          (empty),
        .pop            (pop),
        .o_bcd_byte     (o_bcd_byte),
        .o_last         (o_last)
    );

    initial i_clk = 1'b0;
    always #5 i_clk = ~i_clk;

    // Splits the value into decimal digits and queues the bytes that one
    // conversion should produce, in the order in which they leave the block.
    function automatic void predict_bcd_bytes(input logic [31:0] v, input logic [3:0] cnt,
                                              input logic le);
        logic [3:0]  digit[DIGITS];
        int unsigned rest;
        int          top;
        int          n;
        int          k;
        t_bcd_byte   b;
        rest = v;
        top  = 0;
        for (int d = 0; d < DIGITS; d++) begin
            digit[d] = 4'(rest % 10);
            rest     = rest / 10;
        end
        for (int d = 1; d < DIGITS; d++) begin
            if (digit[d] != 4'd0) begin
                top = d;
            end
        end
        n = (cnt == 4'd0) ? (top + 2) / 2 : int'(cnt);
        if (n > MAX_BYTES) begin
            n = MAX_BYTES;
        end
        for (int i = 0; i < n; i++) begin
            k      = le ? i : n - 1 - i;
            b.bcd  = (k < BCD_BYTES) ? {digit[2*k+1], digit[2*k]} : PAD_BYTE;
            b.last = (i == n - 1);
            bcd_bytes_due.insert(bcd_bytes_due.size(), b);
        end
    endfunction

    function automatic void queue_literal_bytes(input logic [3:0] n, input logic [63:0] lit);
        t_bcd_byte b;
        for (int i = 0; i < int'(n); i++) begin
            b.bcd  = lit[63-8*i -: 8];
            b.last = (i == int'(n) - 1);
            bcd_bytes_due.insert(bcd_bytes_due.size(), b);
        end
    endfunction

    // Values of a random decimal length, so that every natural length turns up,
    // plus full-width noise, values to 99, and powers of ten or one less.
    function automatic logic [31:0] random_value();
        longint lo;
        longint hi;
        int     n;
        lo = 1;
        case ($urandom_range(0, 3))
            0: return $urandom;
            1: return $urandom_range(0, 99);
            2: begin
                n = $urandom_range(1, 10);
                for (int i = 1; i < n; i++) begin
                    lo = lo * 10;
                end
                hi = (n == 10) ? 64'hFFFF_FFFF : lo * 10 - 1;
                if (n == 1) begin
                    lo = 0;
                end
                return $urandom_range(32'(hi), 32'(lo));
            end
            default: begin
                n = $urandom_range(1, 9);
                for (int i = 0; i < n; i++) begin
                    lo = lo * 10;
                end
                return 32'(lo - longint'($urandom_range(0, 1)));
            end
        endcase
    endfunction

    // Leaves push high on return, so that a following item goes out back to back.
    task automatic send_item(input logic [31:0] v, input logic [3:0] cnt, input logic le);
        i_value         <= v;
        i_byte_count    <= cnt;
        i_little_endian <= le;
        push            <= 1'b1;
        @(posedge i_clk);
        while (full) @(posedge i_clk);
    endtask

    task automatic idle_input(input int cycles);
        if (cycles > 0) begin
            push <= 1'b0;
            repeat (cycles) @(posedge i_clk);
        end
    endtask

    task automatic drain_results();
        push <= 1'b0;
        @(posedge i_clk);
        while (bcd_bytes_due.size() != 0) @(posedge i_clk);
        repeat (SETTLE) @(posedge i_clk);
    endtask

    // Receiver: rotates through stall patterns, and holds off for a long
    // stretch once asked to.
    initial begin : rx_side
        int unsigned rx_cyc;
        rx_cyc = 0;
        pop    = 1'b0;
        forever begin
            @(posedge i_clk);
            rx_cyc++;
            if (hold_pending) begin
                hold_pending = 1'b0;
                pop <= 1'b0;
                repeat (LONG_HOLD) @(posedge i_clk);
            end else begin
                case (t_rx_pattern'((rx_cyc / 97) % 4))
                    RX_FREE:   pop <= 1'b1;
                    RX_COIN:   pop <= 1'($urandom_range(0, 1));
                    RX_SPARSE: pop <= (rx_cyc % 5 == 0);
                    default:   pop <= ($urandom_range(0, 9) != 0);
                endcase
            end
        end
    end

    always @(posedge i_clk) begin
        if (pop && !empty) begin
            if (bcd_bytes_due.size() == 0) begin
                $display("%0t: byte with nothing due: expected none, actual %h last %b",
                         $time, o_bcd_byte, o_last);
                mismatch_count++;
            end else begin
                due_byte = bcd_bytes_due.pop_front();
                if (o_bcd_byte !== due_byte.bcd) begin
                    $display("%0t: bcd_byte mismatch: expected %h, actual %h",
                             $time, due_byte.bcd, o_bcd_byte);
                    mismatch_count++;
                end
                if (o_last !== due_byte.last) begin
                    $display("%0t: last mismatch: expected %b, actual %b",
                             $time, due_byte.last, o_last);
                    mismatch_count++;
                end
            end
        end
    end

    always @(posedge i_clk) begin
        if ((push && !full) || (pop && !empty)) begin
            quiet_cycles = 0;
        end else begin
            quiet_cycles++;
        end
        if (quiet_cycles >= STALL_LIMIT) begin
            $display("%0t: no transaction for %0d cycles", $time, STALL_LIMIT);
            $display("Test completed with failures");
            $finish;
        end
    end

    initial begin : main_seq
        int          burst_left;
        logic [3:0]  cnt;
        logic [31:0] val;
        logic        le_bit;

        i_rst_n         = 1'b0;
        push            = 1'b0;
        i_value         = '0;
        i_byte_count    = '0;
        i_little_endian = 1'b0;

        // Rows with n_lit of zero are checked against the predictor.
        stim_table[0]  = '{32'd0,          4'd0,  1'b0, 4'd1, 64'h00_00_00_00_00_00_00_00};
        stim_table[1]  = '{32'd0,          4'd0,  1'b1, 4'd1, 64'h00_00_00_00_00_00_00_00};
        stim_table[2]  = '{32'hFFFF_FFFF,  4'd0,  1'b0, 4'd5, 64'h42_94_96_72_95_00_00_00};
        stim_table[3]  = '{32'hFFFF_FFFF,  4'd0,  1'b1, 4'd5, 64'h95_72_96_94_42_00_00_00};
        stim_table[4]  = '{32'd99,         4'd0,  1'b0, 4'd1, 64'h99_00_00_00_00_00_00_00};
        stim_table[5]  = '{32'd10,         4'd0,  1'b1, 4'd1, 64'h10_00_00_00_00_00_00_00};
        stim_table[6]  = '{32'd100,        4'd0,  1'b0, 4'd2, 64'h01_00_00_00_00_00_00_00};
        stim_table[7]  = '{32'd5,          4'd3,  1'b0, 4'd3, 64'h00_00_05_00_00_00_00_00};
        stim_table[8]  = '{32'd5,          4'd3,  1'b1, 4'd3, 64'h05_00_00_00_00_00_00_00};
        stim_table[9]  = '{32'd9,          4'd8,  1'b0, 4'd8, 64'h00_00_00_00_00_00_00_09};
        stim_table[10] = '{32'hFFFF_FFFF,  4'd15, 1'b1, 4'd8, 64'h95_72_96_94_42_00_00_00};
        stim_table[11] = '{32'd12345678,   4'd2,  1'b0, 4'd2, 64'h56_78_00_00_00_00_00_00};
        stim_table[12] = '{32'd12345678,   4'd1,  1'b1, 4'd1, 64'h78_00_00_00_00_00_00_00};
        stim_table[13] = '{32'd1234567890, 4'd0,  1'b1, 4'd0, 64'h0};
        stim_table[14] = '{32'hAAAA_AAAA,  4'd9,  1'b0, 4'd0, 64'h0};
        stim_table[15] = '{32'h5555_5555,  4'd6,  1'b1, 4'd0, 64'h0};
        stim_table[16] = '{32'h8000_0000,  4'd0,  1'b0, 4'd0, 64'h0};
        stim_table[17] = '{32'd999999999,  4'd0,  1'b0, 4'd0, 64'h0};
        stim_table[18] = '{32'd10000,      4'd0,  1'b1, 4'd0, 64'h0};
        stim_table[19] = '{32'd987654,     4'd7,  1'b1, 4'd0, 64'h0};
        stim_table[20] = '{32'h7FFF_FFFF,  4'd4,  1'b0, 4'd0, 64'h0};

        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        for (int r = 0; r < TABLE_ROWS; r++) begin
            send_item(stim_table[r].value, stim_table[r].cnt, stim_table[r].le);
            if (stim_table[r].n_lit != 4'd0) begin
                queue_literal_bytes(stim_table[r].n_lit, stim_table[r].lit);
            end else begin
                predict_bcd_bytes(stim_table[r].value, stim_table[r].cnt, stim_table[r].le);
            end
            idle_input($urandom_range(0, 3));
        end
        drain_results();

        burst_left = 0;
        for (int i = 0; i < RANDOM_ITEMS; i++) begin
            // The receiver holds off while items keep coming, so the block fills.
            if (i == 120) begin
                hold_pending = 1'b1;
            end
            if (i == 300) begin
                drain_results();
            end
            // Items 200 to 259 go out with no gaps at all.
            if (burst_left == 0) begin
                burst_left = $urandom_range(1, 16);
                if (i < 200 || i >= 260) begin
                    idle_input($urandom_range(1, 12));
                end
            end
            burst_left--;
            cnt    = ($urandom_range(0, 2) == 0) ? 4'd0 : 4'($urandom_range(1, 15));
            val    = random_value();
            le_bit = 1'($urandom_range(0, 1));
            send_item(val, cnt, le_bit);
            predict_bcd_bytes(val, cnt, le_bit);
        end
        drain_results();

        if (mismatch_count == 0) begin
            $display("Test completed successfully");
        end else begin
            $display("Test completed with failures");
        end
        $finish;
    end

endmodule
